// ===== hdl/ccsw_pkg.sv =====
`timescale 1ns / 1ps

package ccsw_pkg;

    localparam logic [2:0] OP_TICK     = 3'd0;
    localparam logic [2:0] OP_SET_TIME = 3'd1;
    localparam logic [2:0] OP_SES_START = 3'd2;
    localparam logic [2:0] OP_ACTIVITY = 3'd3;
    localparam logic [2:0] OP_SES_END  = 3'd4;

    localparam logic [2:0] REG_TICKS_PER_MIN = 3'd0;
    localparam logic [2:0] REG_HB_PERIOD     = 3'd1;
    localparam logic [2:0] REG_OPEN_HOUR     = 3'd2;
    localparam logic [2:0] REG_CLOSE_HOUR    = 3'd3;
    localparam logic [2:0] REG_WARN_TICKS    = 3'd4;
    localparam logic [2:0] REG_EXPIRE_TICKS  = 3'd5;

    localparam logic [5:0] RST_TICKS_PER_MIN = 6'd60;
    localparam logic [5:0] RST_HB_PERIOD     = 6'd20;
    localparam logic [4:0] RST_OPEN_HOUR     = 5'd8;
    localparam logic [4:0] RST_CLOSE_HOUR    = 5'd20;
    localparam logic [5:0] RST_WARN_TICKS    = 6'd19;
    localparam logic [5:0] RST_EXPIRE_TICKS  = 6'd31;

    localparam logic [5:0] RST_MINUTE = 6'd0;
    localparam logic [4:0] RST_HOUR   = 5'd10;
    localparam logic [4:0] RST_DAY    = 5'd1;
    localparam logic [3:0] RST_MONTH  = 4'd1;

    localparam logic [6:0] MINUTES_PER_HOUR = 7'd60;
    localparam logic [5:0] HOURS_PER_DAY    = 6'd24;
    localparam logic [4:0] MONTHS_PER_YEAR  = 5'd12;

    typedef struct packed {
        logic [5:0] minute;
        logic [4:0] hour;
        logic [4:0] day;
        logic [3:0] month;
    } t_cal;

    typedef struct packed {
        logic advance;
        logic load;
    } t_cal_ctl;

    typedef struct packed {
        logic step;
        logic clear;
    } t_hb_ctl;

    // No leap years; out-of-range months count as 31 days.
    function automatic logic [4:0] month_len(input logic [3:0] month);
        logic [4:0] len;
        case (month) inside
            4'd2:                    len = 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
            default:                 len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

// ===== hdl/ccsw_cal.sv =====
`timescale 1ns / 1ps

module ccsw_cal (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ccsw_pkg::t_cal_ctl i_ctl,
    input  ccsw_pkg::t_cal    i_set,
    output ccsw_pkg::t_cal    o_cur,
    output ccsw_pkg::t_cal    o_nxt
);

    ccsw_pkg::t_cal r_cal;
    ccsw_pkg::t_cal n_cal;
    logic [6:0]     w_min_inc;
    logic [5:0]     w_hour_inc;
    logic [5:0]     w_day_inc;
    logic [4:0]     w_month_inc;
    logic [4:0]     w_len;

    assign w_min_inc   = {1'b0, r_cal.minute} + 7'd1;
    assign w_hour_inc  = {1'b0, r_cal.hour} + 6'd1;
    assign w_day_inc   = {1'b0, r_cal.day} + 6'd1;
    assign w_month_inc = {1'b0, r_cal.month} + 5'd1;
    assign w_len       = ccsw_pkg::month_len(r_cal.month);

    always_comb begin
        n_cal = r_cal;
        if (i_ctl.load) begin
            n_cal = i_set;
        end else if (i_ctl.advance) begin
            // ripple the carry up through hour, day and month
            if (w_min_inc < ccsw_pkg::MINUTES_PER_HOUR) begin
                n_cal.minute = w_min_inc[5:0];
            end else begin
                n_cal.minute = 6'd0;
                if (w_hour_inc < ccsw_pkg::HOURS_PER_DAY) begin
                    n_cal.hour = w_hour_inc[4:0];
                end else begin
                    n_cal.hour = 5'd0;
                    if (w_day_inc <= {1'b0, w_len}) begin
                        n_cal.day = w_day_inc[4:0];
                    end else begin
                        n_cal.day = 5'd1;
                        n_cal.month = (w_month_inc > ccsw_pkg::MONTHS_PER_YEAR) ?
                                      4'd1 : w_month_inc[3:0];
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal.minute <= ccsw_pkg::RST_MINUTE;
            r_cal.hour   <= ccsw_pkg::RST_HOUR;
            r_cal.day    <= ccsw_pkg::RST_DAY;
            r_cal.month  <= ccsw_pkg::RST_MONTH;
        end else begin
            r_cal <= n_cal;
        end
    end

    assign o_cur = r_cal;
    assign o_nxt = n_cal;

endmodule

// ===== hdl/ccsw_hb.sv =====
`timescale 1ns / 1ps

module ccsw_hb (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_period_we,
    input  logic [5:0]        i_period,
    input  logic [5:0]        i_tick,
    input  ccsw_pkg::t_hb_ctl i_ctl,
    output logic              o_hb,
    output logic              o_busy
);

    // r_phase tracks tick_count mod period; a period write rebuilds it
    // with a bit-serial remainder, one tick bit per cycle.
    logic [5:0] r_period;
    logic [5:0] r_phase;
    logic [5:0] n_phase;
    logic [5:0] w_phase_inc;
    logic       r_busy;
    logic [2:0] r_cnt;
    logic [5:0] r_rem;
    logic [6:0] w_rem_sh;
    logic [6:0] w_rem_nxt;

    assign w_phase_inc = r_phase + 6'd1;
    assign n_phase     = (w_phase_inc == r_period) ? 6'd0 : w_phase_inc;
    assign o_hb        = (r_period != 6'd0) && (n_phase == 6'd0);
    assign o_busy      = r_busy;

    assign w_rem_sh  = {r_rem, i_tick[r_cnt]};
    assign w_rem_nxt = (w_rem_sh >= {1'b0, r_period}) ?
                       (w_rem_sh - {1'b0, r_period}) : w_rem_sh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= ccsw_pkg::RST_HB_PERIOD;
            r_phase  <= 6'd0;
            r_busy   <= 1'b0;
            r_cnt    <= 3'd0;
            r_rem    <= 6'd0;
        end else if (i_period_we) begin
            r_period <= i_period;
            r_busy   <= 1'b1;
            r_cnt    <= 3'd5;
            r_rem    <= 6'd0;
        end else if (r_busy) begin
            r_rem <= w_rem_nxt[5:0];
            if (r_cnt == 3'd0) begin
                r_busy  <= 1'b0;
                r_phase <= w_rem_nxt[5:0];
            end else begin
                r_cnt <= r_cnt - 3'd1;
            end
        end else if (i_ctl.clear) begin
            r_phase <= 6'd0;
        end else if (i_ctl.step) begin
            r_phase <= n_phase;
        end
    end

endmodule

// ===== hdl/calendar_clock_with_session_watch.sv =====
`timescale 1ns / 1ps
// The input is captured in the input register and its result in the result register,
// where it is held until taken.
// Throughput: one item per cycle unless a result waits on i_out_ready; the input
// register can take a new item while a result waits. A heartbeat_period write holds
// o_in_ready low while the heartbeat phase is rebuilt by the bit-serial remainder unit.
// Reset (i_rst_n low, synchronous): calendar 1 Jan 10:00, registers to defaults, no items.
module calendar_clock_with_session_watch (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [2:0] i_cfg_addr,
    input  logic [5:0] i_cfg_data,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [2:0] i_operation,
    input  logic       i_terminal_busy,
    input  logic [4:0] i_set_day,
    input  logic [3:0] i_set_month,
    input  logic [4:0] i_set_hour,
    input  logic [5:0] i_set_minute,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [5:0] o_minute_out,
    output logic [4:0] o_hour_out,
    output logic [4:0] o_day_out,
    output logic [3:0] o_month_out,
    output logic       o_heartbeat,
    output logic       o_lock_signal,
    output logic       o_unlock_signal,
    output logic       o_idle_warning,
    output logic       o_session_expired
);

    // configuration
    logic [5:0] r_ticks_per_min;
    logic [4:0] r_open_hour;
    logic [4:0] r_close_hour;
    logic [5:0] r_warn_ticks;
    logic [5:0] r_expire_ticks;
    logic       w_period_we;

    // input register
    logic           r_in_valid;
    logic [2:0]     r_op;
    logic           r_term_busy;
    ccsw_pkg::t_cal r_set;

    // block state
    logic [5:0] r_tick;
    logic [5:0] n_tick;
    logic [5:0] r_idle;
    logic [5:0] n_idle;
    logic       r_armed;
    logic       n_armed;
    logic       r_pend;
    logic       n_pend;

    // result register
    logic           r_out_valid;
    ccsw_pkg::t_cal r_out_cal;
    logic           r_hb;
    logic           r_lock;
    logic           r_unlock;
    logic           r_warn;
    logic           r_expired;

    logic              w_adv;
    logic              w_fire;
    logic              w_hb_busy;
    logic              w_hb_raw;
    logic [5:0]        w_tick_inc;
    logic [5:0]        w_idle_inc;
    logic              w_outside;
    logic              w_roll;
    logic              n_hb;
    logic              n_lock;
    logic              n_unlock;
    logic              n_warn;
    logic              n_expired;
    logic              w_busy_eff;
    ccsw_pkg::t_cal    w_cal_cur;
    ccsw_pkg::t_cal    w_cal_nxt;
    ccsw_pkg::t_cal_ctl w_cal_ctl;
    ccsw_pkg::t_hb_ctl  w_hb_ctl;

    assign w_period_we = i_cfg_we && (i_cfg_addr == ccsw_pkg::REG_HB_PERIOD);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ticks_per_min <= ccsw_pkg::RST_TICKS_PER_MIN;
            r_open_hour     <= ccsw_pkg::RST_OPEN_HOUR;
            r_close_hour    <= ccsw_pkg::RST_CLOSE_HOUR;
            r_warn_ticks    <= ccsw_pkg::RST_WARN_TICKS;
            r_expire_ticks  <= ccsw_pkg::RST_EXPIRE_TICKS;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                ccsw_pkg::REG_TICKS_PER_MIN: r_ticks_per_min <= i_cfg_data;
                ccsw_pkg::REG_OPEN_HOUR:     r_open_hour     <= i_cfg_data[4:0];
                ccsw_pkg::REG_CLOSE_HOUR:    r_close_hour    <= i_cfg_data[4:0];
                ccsw_pkg::REG_WARN_TICKS:    r_warn_ticks    <= i_cfg_data;
                ccsw_pkg::REG_EXPIRE_TICKS:  r_expire_ticks  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_adv      = !r_out_valid || i_out_ready;
    assign w_fire     = r_in_valid && w_adv && !w_hb_busy;
    assign o_in_ready = !w_hb_busy && (!r_in_valid || w_adv);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_op         <= i_operation;
            r_term_busy  <= i_terminal_busy;
            r_set.day    <= i_set_day;
            r_set.month  <= i_set_month;
            r_set.hour   <= i_set_hour;
            r_set.minute <= i_set_minute;
        end
    end

    assign w_tick_inc = r_tick + 6'd1;
    assign w_idle_inc = r_idle + 6'd1;
    assign w_roll     = (w_tick_inc >= r_ticks_per_min);
    // window check uses the calendar from before this tick
    assign w_outside  = (w_cal_cur.hour > r_close_hour) ||
                        ((w_cal_cur.hour == r_close_hour) && (w_cal_cur.minute != 6'd0)) ||
                        (w_cal_cur.hour < r_open_hour);

    always_comb begin
        n_tick     = r_tick;
        n_idle     = r_idle;
        n_armed    = r_armed;
        n_pend     = r_pend;
        n_hb       = 1'b0;
        n_lock     = 1'b0;
        n_unlock   = 1'b0;
        n_warn     = 1'b0;
        n_expired  = 1'b0;
        w_busy_eff = r_term_busy;
        w_cal_ctl  = '0;
        w_hb_ctl   = '0;
        if (w_fire) begin
            unique case (r_op)
                ccsw_pkg::OP_TICK: begin
                    if (r_armed) begin
                        n_idle = w_idle_inc;
                        if (w_idle_inc == r_warn_ticks) begin
                            n_warn = 1'b1;
                        end else if (w_idle_inc == r_expire_ticks) begin
                            n_expired  = 1'b1;
                            n_idle     = 6'd0;
                            n_armed    = 1'b0;
                            w_busy_eff = 1'b1;
                        end
                    end
                    if (!w_busy_eff && w_outside) begin
                        n_lock = 1'b1;
                        n_pend = 1'b1;
                    end else if (r_pend && !w_outside) begin
                        n_unlock = 1'b1;
                        n_pend   = 1'b0;
                    end
                    n_hb           = w_hb_raw && (w_tick_inc != 6'd0);
                    n_tick         = w_roll ? 6'd0 : w_tick_inc;
                    w_cal_ctl.advance = w_roll;
                    w_hb_ctl.step  = 1'b1;
                    w_hb_ctl.clear = w_roll;
                end
                ccsw_pkg::OP_SET_TIME: begin
                    n_tick         = 6'd0;
                    w_cal_ctl.load = 1'b1;
                    w_hb_ctl.clear = 1'b1;
                end
                ccsw_pkg::OP_SES_START: begin
                    n_armed = 1'b1;
                    n_idle  = 6'd0;
                end
                ccsw_pkg::OP_ACTIVITY: begin
                    n_idle = 6'd0;
                end
                ccsw_pkg::OP_SES_END: begin
                    n_armed = 1'b0;
                    n_idle  = 6'd0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick  <= 6'd0;
            r_idle  <= 6'd0;
            r_armed <= 1'b0;
            r_pend  <= 1'b1;
        end else begin
            r_tick  <= n_tick;
            r_idle  <= n_idle;
            r_armed <= n_armed;
            r_pend  <= n_pend;
        end
    end

    ccsw_cal u_cal (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_cal_ctl),
        .i_set   (r_set),
        .o_cur   (w_cal_cur),
        .o_nxt   (w_cal_nxt)
    );

    ccsw_hb u_hb (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_period_we (w_period_we),
        .i_period    (i_cfg_data),
        .i_tick      (r_tick),
        .i_ctl       (w_hb_ctl),
        .o_hb        (w_hb_raw),
        .o_busy      (w_hb_busy)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= w_fire;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out_cal <= w_cal_nxt;
            r_hb      <= n_hb;
            r_lock    <= n_lock;
            r_unlock  <= n_unlock;
            r_warn    <= n_warn;
            r_expired <= n_expired;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_minute_out      = r_out_cal.minute;
    assign o_hour_out        = r_out_cal.hour;
    assign o_day_out         = r_out_cal.day;
    assign o_month_out       = r_out_cal.month;
    assign o_heartbeat       = r_hb;
    assign o_lock_signal     = r_lock;
    assign o_unlock_signal   = r_unlock;
    assign o_idle_warning    = r_warn;
    assign o_session_expired = r_expired;

endmodule
